[src/efd_pkg.sv]
package efd_pkg;

   // Frame geometry and sizes.
   localparam int BUFFER_BYTES = 128;
   localparam int HEADER_BYTES = 3;
   localparam int CAPACITY     = BUFFER_BYTES - HEADER_BYTES;
   localparam int CNT_W        = $clog2(CAPACITY + 1);
   localparam int BYTE_W       = 8;
   localparam int INDEX_W      = 7;
   localparam int RSP_DATA_W   = 32;

   // Special line bytes.
   localparam logic [BYTE_W-1:0] SYN_BYTE = 8'hFF;
   localparam logic [BYTE_W-1:0] ESC_BYTE = 8'hFD;

   // Parser stages.
   typedef enum logic [2:0] {
      ST_WAIT   = 3'd0,
      ST_CMD    = 3'd1,
      ST_SIZE   = 3'd2,
      ST_DATA   = 3'd3,
      ST_IGNORE = 3'd4
   } stage_type;

   // One result beat as produced by the parser.
   typedef struct packed {
      logic [BYTE_W-1:0]  command;
      logic [BYTE_W-1:0]  declared_size;
      logic [BYTE_W-1:0]  payload_byte;
      logic [INDEX_W-1:0] byte_index;
      logic               is_checksum_byte;
      logic               checksum_ok;
   } result_type;

   // Occupancy of the output skid stage.
   typedef struct packed {
      logic main_valid;
      logic skid_valid;
   } skid_status_type;

endpackage

[src/efd_parser.sv]
module efd_parser (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [efd_pkg::BYTE_W-1:0]       rx_byte,
   input  logic                             chunk_end,
   output logic                             res_valid,
   output efd_pkg::result_type              res
);

   efd_pkg::stage_type               stage_ff, stage_in;
   logic                             esc_ff, esc_in;
   logic [efd_pkg::BYTE_W-1:0]       sum_ff, sum_in;
   logic [efd_pkg::BYTE_W-1:0]       cmd_ff, cmd_in;
   logic [efd_pkg::BYTE_W-1:0]       size_ff, size_in;
   logic [efd_pkg::CNT_W-1:0]        count_ff, count_in;

   logic                             is_syn;
   logic                             active;
   logic                             take;
   logic [efd_pkg::BYTE_W-1:0]       value;
   logic [efd_pkg::BYTE_W-1:0]       sum_add;
   logic                             closing;
   logic [efd_pkg::CNT_W:0]          count_inc;

   // Unescaping and running checksum, shared by both blocks below.
   assign is_syn    = (rx_byte == efd_pkg::SYN_BYTE);
   assign active    = (stage_ff == efd_pkg::ST_CMD) || (stage_ff == efd_pkg::ST_SIZE) ||
                      (stage_ff == efd_pkg::ST_DATA);
   assign value     = esc_ff ? rx_byte + 8'd1 : rx_byte;
   assign take      = esc_ff || (rx_byte != efd_pkg::ESC_BYTE);
   assign sum_add   = sum_ff + value;
   assign closing   = (32'(count_ff) == 32'(size_ff));
   assign count_inc = {1'b0, count_ff} + 1'b1;

   // Next state of the parser.
   always_comb begin
      stage_in = stage_ff;
      esc_in   = esc_ff;
      sum_in   = sum_ff;
      cmd_in   = cmd_ff;
      size_in  = size_ff;
      count_in = count_ff;
      if (accept) begin
         if (is_syn) begin
            stage_in = efd_pkg::ST_CMD;
            esc_in   = 1'b0;
            sum_in   = efd_pkg::SYN_BYTE;
            cmd_in   = '0;
            size_in  = '0;
            count_in = '0;
         end else if (active) begin
            esc_in = !esc_ff && (rx_byte == efd_pkg::ESC_BYTE);
            if (take) begin
               sum_in = sum_add;
               unique case (stage_ff)
                  efd_pkg::ST_CMD: begin
                     if (value != '0) begin
                        cmd_in   = value;
                        stage_in = efd_pkg::ST_SIZE;
                     end
                  end
                  efd_pkg::ST_SIZE: begin
                     size_in  = value;
                     count_in = '0;
                     stage_in = efd_pkg::ST_DATA;
                  end
                  default: begin
                     count_in = count_inc[efd_pkg::CNT_W-1:0];
                     if (closing || (32'(count_inc) >= efd_pkg::CAPACITY)) begin
                        stage_in = efd_pkg::ST_IGNORE;
                     end
                  end
               endcase
            end
         end
         // A chunk boundary always drops the parser back to hunting for SYN.
         if (chunk_end) begin
            stage_in = efd_pkg::ST_WAIT;
            esc_in   = 1'b0;
         end
      end
   end

   // Result beat for a taken payload or checksum byte.
   always_comb begin
      res_valid            = accept && !is_syn && take && (stage_ff == efd_pkg::ST_DATA);
      res.command          = cmd_ff;
      res.declared_size    = size_ff;
      res.payload_byte     = value;
      res.byte_index       = efd_pkg::INDEX_W'(count_ff);
      res.is_checksum_byte = closing;
      res.checksum_ok      = closing && (sum_add == '0);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= efd_pkg::ST_WAIT;
         esc_ff   <= 1'b0;
         sum_ff   <= '0;
         cmd_ff   <= '0;
         size_ff  <= '0;
         count_ff <= '0;
      end else begin
         stage_ff <= stage_in;
         esc_ff   <= esc_in;
         sum_ff   <= sum_in;
         cmd_ff   <= cmd_in;
         size_ff  <= size_in;
         count_ff <= count_in;
      end
   end

endmodule

[src/efd_skid.sv]
module efd_skid (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  efd_pkg::result_type      push_data,
   output logic                     space,
   output logic                     out_valid,
   input  logic                     out_ready,
   output efd_pkg::result_type      out_data,
   output efd_pkg::skid_status_type status
);

   logic                main_valid_ff, main_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   efd_pkg::result_type main_ff, main_in;
   efd_pkg::result_type skid_ff, skid_in;
   logic                pop;

   // Space is taken from a register so the ready path does not cross the block.
   assign space     = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign pop       = main_valid_ff && out_ready;
   assign status    = '{main_valid: main_valid_ff, skid_valid: skid_valid_ff};

   // Two-entry output stage: the main register faces the consumer, the skid catches
   // a beat that arrives while the main one is stalled.
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

[src/escaped_frame_deframer.sv]
// Escaped frame deframer. Takes one raw serial byte per input beat and, for each
// unescaped payload or checksum byte of a frame (SYN 0xFF, command, size, payload,
// checksum), returns one result beat carrying the frame's command and size, the
// byte, its index after the header, a last flag on the checksum byte and, there,
// the checksum verdict. 0xFF always restarts the parser; 0xFD escapes the next
// byte (taken plus one); tlast on the input ends a chunk and the parser then waits
// for a new SYN. The block takes one beat every cycle: the per-byte parser update
// sits between the parser state registers and a two-entry output register, so a
// stalled consumer holds input only once both output entries are full. A result is
// registered in the main output entry, or in the skid entry behind a stalled one.
module escaped_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tlast,   // chunk_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [efd_pkg::RSP_DATA_W-1:0] rsp_tdata,
                                    // [7:0] command, [15:8] declared_size,
                                    // [23:16] payload_byte, [30:24] byte_index, [31] zero
   output logic        rsp_tlast,   // is_checksum_byte
   output logic        rsp_tuser    // checksum_ok
);

   logic                     accept;
   logic                     res_valid;
   efd_pkg::result_type      res;
   efd_pkg::result_type      out_data;
   efd_pkg::skid_status_type status;

   assign accept = req_tvalid && req_tready;

   // Per-byte parser.
   efd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_tdata),
      .chunk_end (req_tlast),
      .res_valid (res_valid),
      .res       (res)
   );

   // Output register with skid entry.
   efd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .space     (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data),
      .status    (status)
   );

   // Pack the result beat.
   assign rsp_tdata = {1'b0, out_data.byte_index, out_data.payload_byte,
                       out_data.declared_size, out_data.command};
   assign rsp_tlast = out_data.is_checksum_byte;
   assign rsp_tuser = out_data.checksum_ok;

`ifndef ASSERT_OFF
   // The skid entry is only ever filled behind an occupied main entry.
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      status.skid_valid |-> status.main_valid)
      else $error("skid entry valid while main entry empty");

   // A new result arriving at a stalled, occupied output must land in the skid entry.
   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      (res_valid && status.main_valid && !rsp_tready) |=> status.skid_valid)
      else $error("result lost at stalled output");

   // A good checksum is only reported on the closing byte of a frame.
   a_ok_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("checksum_ok set on a non-checksum beat");
`endif

endmodule

[tb/sv/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int BYTE_TARGET   = 1550;
   localparam int DRAIN_CYCLES  = 16;
   localparam int REPORT_LIMIT  = 10;

   // One row of the directed stimulus. When typed is set, the row carries its
   // own expected outcome: want says whether a result beat follows, rsp is it.
   typedef struct packed {
      logic [7:0]          rx;
      logic                chunk_end;
      logic                typed;
      logic                want;
      efd_pkg::result_type rsp;
   } directed_row_type;

   localparam directed_row_type DIRECTED_ROWS [25] = '{
      // A stray byte before any SYN is dropped.
      '{8'h41, 1'b0, 1'b1, 1'b0, '0},
      // SYN, a zero command byte that is skipped, then command 0x12 and size 2.
      '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{8'h12, 1'b0, 1'b0, 1'b0, '0},
      '{8'h02, 1'b0, 1'b0, 1'b0, '0},
      // Escaped 0xFE becomes the payload byte 0xFF.
      '{8'hFD, 1'b0, 1'b0, 1'b0, '0},
      '{8'hFE, 1'b0, 1'b1, 1'b1, '{8'h12, 8'h02, 8'hFF, 7'd0, 1'b0, 1'b0}},
      '{8'h00, 1'b0, 1'b1, 1'b1, '{8'h12, 8'h02, 8'h00, 7'd1, 1'b0, 1'b0}},
      // Checksum that brings the sum to zero.
      '{8'hEE, 1'b0, 1'b1, 1'b1, '{8'h12, 8'h02, 8'hEE, 7'd2, 1'b1, 1'b1}},
      // Anything after a closed frame is dropped.
      '{8'h55, 1'b0, 1'b1, 1'b0, '0},
      // Empty frame with a bad checksum.
      '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{8'h07, 1'b0, 1'b1, 1'b1, '{8'h01, 8'h00, 8'h07, 7'd0, 1'b1, 1'b0}},
      // An escape followed by SYN still restarts the frame.
      '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
      '{8'h03, 1'b0, 1'b0, 1'b0, '0},
      '{8'hFD, 1'b0, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
      '{8'h04, 1'b0, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, 1'b0, '0},
      // Chunk end in the middle of a frame: the byte counts, the rest is dropped.
      '{8'h80, 1'b1, 1'b1, 1'b1, '{8'h04, 8'h01, 8'h80, 7'd0, 1'b0, 1'b0}},
      '{8'h00, 1'b0, 1'b1, 1'b0, '0},
      // An escape pending at chunk end goes away with the chunk.
      '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
      '{8'h05, 1'b0, 1'b0, 1'b0, '0},
      '{8'hFD, 1'b1, 1'b1, 1'b0, '0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [7:0] rx_byte
   logic        req_tlast = 1'b0;  // chunk_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [7:0] command, [15:8] declared_size,
                                   // [23:16] payload_byte, [30:24] byte_index, [31] zero
   logic        rsp_tlast;         // is_checksum_byte
   logic        rsp_tuser;         // checksum_ok

   // Outcome carried along with the directed beat on the bus.
   logic                row_typed = 1'b0;
   logic                row_want = 1'b0;
   efd_pkg::result_type row_rsp = '0;

   // Deframer state as the testbench sees it.
   efd_pkg::stage_type  stage = efd_pkg::ST_WAIT;
   bit                  esc_armed = 1'b0;
   logic [7:0]          frame_sum = '0;
   logic [7:0]          frame_cmd = '0;
   logic [7:0]          frame_len = '0;
   int                  stored_count = 0;

   efd_pkg::result_type due_bytes [$];

   int cycle_count = 0;
   int mismatches = 0;
   int beats_in = 0;
   int useful_beats = 0;
   int results_checked = 0;
   int closed_frames = 0;
   int good_frames = 0;
   int overruns = 0;
   int tx_idle_pct = 0;
   int rx_stall_pct = 0;

   escaped_frame_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the deframer by one received byte; returns 1 when a result beat
   // comes out of it.
   function automatic bit deframe_byte(input logic [7:0] rx, input logic chunk_end,
                                       output efd_pkg::result_type beat);
      logic [7:0] value;
      bit take;
      bit closing;
      bit produced;
      beat = '0;
      produced = 1'b0;
      if (rx == efd_pkg::SYN_BYTE) begin
         stage = efd_pkg::ST_CMD;
         esc_armed = 1'b0;
         frame_sum = efd_pkg::SYN_BYTE;
         frame_cmd = '0;
         frame_len = '0;
         stored_count = 0;
      end else if (stage != efd_pkg::ST_WAIT && stage != efd_pkg::ST_IGNORE) begin
         take = 1'b1;
         value = rx;
         if (esc_armed) begin
            esc_armed = 1'b0;
            value = rx + 8'd1;
         end else if (rx == efd_pkg::ESC_BYTE) begin
            esc_armed = 1'b1;
            take = 1'b0;
         end
         if (take) begin
            frame_sum = frame_sum + value;
            case (stage)
               efd_pkg::ST_CMD: begin
                  // A zero command byte is skipped.
                  if (value != 8'h00) begin
                     frame_cmd = value;
                     stage = efd_pkg::ST_SIZE;
                  end
               end
               efd_pkg::ST_SIZE: begin
                  frame_len = value;
                  stored_count = 0;
                  stage = efd_pkg::ST_DATA;
               end
               default: begin
                  closing = (stored_count == int'(frame_len));
                  beat.command = frame_cmd;
                  beat.declared_size = frame_len;
                  beat.payload_byte = value;
                  beat.byte_index = efd_pkg::INDEX_W'(stored_count);
                  beat.is_checksum_byte = closing;
                  beat.checksum_ok = closing && (frame_sum == 8'h00);
                  produced = 1'b1;
                  stored_count++;
                  if (closing || stored_count >= efd_pkg::CAPACITY) begin
                     stage = efd_pkg::ST_IGNORE;
                  end
               end
            endcase
         end
      end
      if (chunk_end) begin
         stage = efd_pkg::ST_WAIT;
         esc_armed = 1'b0;
      end
      return produced;
   endfunction

   function automatic string show_beat(input efd_pkg::result_type b);
      return $sformatf("cmd %h size %h byte %h idx %0d last %b ok %b", b.command,
                       b.declared_size, b.payload_byte, b.byte_index,
                       b.is_checksum_byte, b.checksum_ok);
   endfunction

   task automatic flag_error(input string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("ERROR at %0t ns: %s", $time, what);
      end
   endtask

   task automatic set_idling(input int phase);
      case (phase)
         1: begin
            tx_idle_pct = 72;
            rx_stall_pct = 0;
         end
         2: begin
            tx_idle_pct = 0;
            rx_stall_pct = 72;
         end
         3: begin
            tx_idle_pct = 19;
            rx_stall_pct = 19;
         end
         default: begin
            tx_idle_pct = 0;
            rx_stall_pct = 0;
         end
      endcase
   endtask

   // Drive one byte beat at the falling edge and hold it until it is taken.
   task automatic send_beat(input logic [7:0] rx, input logic chunk_end,
                            input logic typed = 1'b0, input logic want = 1'b0,
                            input efd_pkg::result_type rsp = '0);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= rx;
      req_tlast <= chunk_end;
      row_typed <= typed;
      row_want <= want;
      row_rsp <= rsp;
      do @(posedge clock); while (!req_tready);
   endtask

   // Send one frame byte on the line, escaping it where it must be and now
   // and then where it need not be. A zero byte cannot be escaped.
   task automatic send_value(input logic [7:0] value, input logic chunk_end);
      if (value == efd_pkg::SYN_BYTE || value == efd_pkg::ESC_BYTE ||
          (value != 8'h00 && $urandom_range(0, 9) == 0)) begin
         send_beat(efd_pkg::ESC_BYTE, 1'b0);
         send_beat(value - 8'd1, chunk_end);
      end else begin
         send_beat(value, chunk_end);
      end
   endtask

   // A mostly well-formed frame with random content; some are cut short, some
   // carry a bad checksum, a few run past the buffer.
   task automatic send_frame();
      logic [7:0] body [$];
      logic [7:0] sum;
      logic [7:0] value;
      int size;
      int n_pay;
      int keep;
      int pick;
      bit cut;
      bit end_chunk;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         size = $urandom_range(0, 8);
      end else if (pick < 92) begin
         size = $urandom_range(9, 40);
      end else if (pick < 96) begin
         size = $urandom_range(41, efd_pkg::CAPACITY - 1);
      end else begin
         case ($urandom_range(0, 3))
            0: size = efd_pkg::CAPACITY - 1;
            1: size = efd_pkg::CAPACITY;
            2: size = efd_pkg::CAPACITY + 1;
            default: size = 255;
         endcase
      end
      if ($urandom_range(0, 9) == 0) begin
         body.push_back(8'h00);
      end
      body.push_back(8'($urandom_range(1, 255)));
      body.push_back(8'(size));
      n_pay = (size < efd_pkg::CAPACITY) ? size
                                         : efd_pkg::CAPACITY + $urandom_range(0, 3);
      for (int i = 0; i < n_pay; i++) begin
         case ($urandom_range(0, 9))
            0: value = efd_pkg::SYN_BYTE;
            1: value = efd_pkg::ESC_BYTE;
            2: value = 8'h00;
            default: value = 8'($urandom);
         endcase
         body.push_back(value);
      end
      // Closing checksum, corrupted now and then.
      if (size < efd_pkg::CAPACITY) begin
         sum = efd_pkg::SYN_BYTE;
         foreach (body[i]) sum = sum + body[i];
         value = 8'h00 - sum;
         if ($urandom_range(0, 99) < 15) begin
            value = value + 8'($urandom_range(1, 255));
         end
         body.push_back(value);
      end
      cut = ($urandom_range(0, 99) < 8);
      keep = cut ? $urandom_range(1, body.size()) : body.size();
      end_chunk = ($urandom_range(0, 3) == 0);
      send_beat(efd_pkg::SYN_BYTE, 1'b0);
      for (int i = 0; i < keep; i++) begin
         send_value(body[i], end_chunk && (i == keep - 1));
      end
      if (cut && $urandom_range(0, 2) == 0) begin
         send_beat(efd_pkg::ESC_BYTE, 1'b1);
      end
      // Trailing junk after the frame; the deframer drops it unless a cut frame is still open.
      if ($urandom_range(0, 99) < 15) begin
         for (int i = $urandom_range(1, 3); i > 0; i--) begin
            send_beat(8'($urandom_range(0, 254)), $urandom_range(0, 4) == 0);
         end
      end
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
   end

   // Predict on every accepted byte beat, check every accepted result beat.
   always @(posedge clock) begin : monitor
      efd_pkg::result_type predicted;
      efd_pkg::result_type seen;
      efd_pkg::result_type oldest;
      bit produced;
      bit active;
      cycle_count++;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            active = (req_tdata == efd_pkg::SYN_BYTE) ||
                     (stage != efd_pkg::ST_WAIT && stage != efd_pkg::ST_IGNORE);
            produced = deframe_byte(req_tdata, req_tlast, predicted);
            beats_in++;
            if (active) begin
               useful_beats++;
            end
            if (row_typed) begin
               if (row_want) begin
                  due_bytes.push_back(row_rsp);
               end
            end else if (produced) begin
               due_bytes.push_back(predicted);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.command = rsp_tdata[7:0];
            seen.declared_size = rsp_tdata[15:8];
            seen.payload_byte = rsp_tdata[23:16];
            seen.byte_index = rsp_tdata[30:24];
            seen.is_checksum_byte = rsp_tlast;
            seen.checksum_ok = rsp_tuser;
            if (due_bytes.size() == 0) begin
               flag_error({"result beat with none due: ", show_beat(seen)});
            end else begin
               oldest = due_bytes.pop_front();
               results_checked++;
               if (oldest.is_checksum_byte) begin
                  closed_frames++;
               end
               if (oldest.checksum_ok) begin
                  good_frames++;
               end
               if (!oldest.is_checksum_byte &&
                   oldest.byte_index == efd_pkg::INDEX_W'(efd_pkg::CAPACITY - 1)) begin
                  overruns++;
               end
               if (seen !== oldest || rsp_tdata[31] !== 1'b0) begin
                  flag_error({"expected ", show_beat(oldest), ", got ", show_beat(seen),
                              $sformatf(" pad %b", rsp_tdata[31])});
               end
            end
         end
      end
   end

   // Give up on a hung run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("tb_top: errors");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows, no idling.
      set_idling(0);
      foreach (DIRECTED_ROWS[i]) begin
         send_beat(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].chunk_end, DIRECTED_ROWS[i].typed,
                   DIRECTED_ROWS[i].want, DIRECTED_ROWS[i].rsp);
      end

      // Random frames and noise, rotating through the idling phases.
      while (beats_in < BYTE_TARGET) begin
         set_idling((beats_in / 150) % 4);
         if ($urandom_range(0, 99) < 10) begin
            for (int i = $urandom_range(1, 6); i > 0; i--) begin
               send_beat(8'($urandom), $urandom_range(0, 9) == 0);
            end
         end else begin
            send_frame();
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      // Drain what is still due, then watch for strays.
      set_idling(0);
      while (due_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (due_bytes.size() != 0) begin
         flag_error($sformatf("%0d result beats never arrived", due_bytes.size()));
      end

      $display("Sent %0d byte beats (%0d inside frames), checked %0d result beats.",
               beats_in, useful_beats, results_checked);
      $display("Frames closed: %0d, with a good checksum: %0d, buffer overruns: %0d.",
               closed_frames, good_frames, overruns);
      if (mismatches == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
